/* sv/whp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the RIFF/WAVE header parser.
// Used by whp_parse, whp_div and wav_header_parser_core; depends on nothing.
package whp_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned POS_W  = 5;

  localparam logic [WORD_W-1:0] SIG_RIFF = 32'h4646_4952;
  localparam logic [WORD_W-1:0] SIG_WAVE = 32'h4556_4157;
  localparam logic [WORD_W-1:0] SIG_FMT  = 32'h2074_6D66;
  localparam logic [WORD_W-1:0] SIG_DATA = 32'h6174_6164;

  localparam logic [POS_W-1:0]  FMT_BODY_LEN = 5'd20;
  localparam logic [WORD_W-1:0] FMT_BASE_LEN = 32'd16;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_NOT_RIFF = 3'd1,
    STAT_NOT_WAVE = 3'd2,
    STAT_TRUNC    = 3'd3,
    STAT_ZERO     = 3'd4
  } status_t;

  typedef enum logic [7:0] {
    PH_RIFF  = 8'b0000_0001,
    PH_SIZE  = 8'b0000_0010,
    PH_WAVE  = 8'b0000_0100,
    PH_ID    = 8'b0000_1000,
    PH_FMT   = 8'b0001_0000,
    PH_DATA  = 8'b0010_0000,
    PH_CSIZE = 8'b0100_0000,
    PH_SKIP  = 8'b1000_0000
  } phase_t;

  // Result request from the parser; depth, rate and channels are zero unless status is OK
  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [HALF_W-1:0] depth;
    logic [WORD_W-1:0] rate;
    logic [HALF_W-1:0] channels;
    logic [WORD_W-1:0] data_len;
    logic [WORD_W-1:0] byte_rate;
  } emit_t;

endpackage

/* sv/whp_div.sv */
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Depends on whp_pkg for the word width.
module whp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [whp_pkg::WORD_W-1:0]  dividend,
  input  logic [whp_pkg::WORD_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [whp_pkg::WORD_W-1:0]  quotient
);

  localparam int unsigned CNT_W = $clog2(whp_pkg::WORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(whp_pkg::WORD_W - 1);

  logic [CNT_W-1:0]           cnt;
  logic [whp_pkg::WORD_W-1:0] rem;
  logic [whp_pkg::WORD_W-1:0] quo;
  logic [whp_pkg::WORD_W-1:0] den;
  logic [whp_pkg::WORD_W:0]   partial;
  logic [whp_pkg::WORD_W:0]   trial;

  assign partial  = {rem, quo[whp_pkg::WORD_W-1]};
  assign trial    = partial - {1'b0, den};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_LAST) busy <= 1'b0;
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (busy) begin
      if (!trial[whp_pkg::WORD_W]) begin
        rem <= trial[whp_pkg::WORD_W-1:0];
        quo <= {quo[whp_pkg::WORD_W-2:0], 1'b1};
      end else begin
        rem <= partial[whp_pkg::WORD_W-1:0];
        quo <= {quo[whp_pkg::WORD_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* sv/whp_parse.sv */
`timescale 1ns / 1ps
// Byte-wise chunk parser: signature checks, fmt fields, chunk skipping.
// Depends on whp_pkg; raises an emit_t request on the byte that ends or fails the header.
module whp_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       byte_value,
  input  logic             end_of_file,
  output whp_pkg::emit_t   emit
);

  whp_pkg::phase_t                phase, phase_next;
  logic [whp_pkg::POS_W-1:0]      pos, pos_next, pos_inc;
  logic [whp_pkg::WORD_W-1:0]     gw, gw_next, gw_new;
  logic [whp_pkg::WORD_W-1:0]     skip, skip_next;
  logic [whp_pkg::WORD_W-1:0]     fmt_len, fmt_len_next;
  logic                           seen_fmt, seen_fmt_next;
  logic                           seen_data, seen_data_next;
  logic [whp_pkg::HALF_W-1:0]     chans, chans_next;
  logic [whp_pkg::WORD_W-1:0]     rate, rate_next;
  logic [whp_pkg::WORD_W-1:0]     brate, brate_next;
  logic [whp_pkg::HALF_W-1:0]     depth, depth_next;
  logic [whp_pkg::WORD_W-1:0]     dsize, dsize_next;
  logic                           reported, reported_next;
  logic                           do_end;
  logic                           do_emit;
  whp_pkg::status_t               stat;
  logic [whp_pkg::WORD_W-1:0]     pad_size;
  logic [whp_pkg::WORD_W-1:0]     ext_size;

  assign gw_new   = {byte_value, gw[whp_pkg::WORD_W-1:8]};
  assign pos_inc  = pos + 1'b1;
  // padded skip lengths, modulo 2^32
  assign pad_size = (gw_new + 1'b1) & ~32'd1;
  assign ext_size = (fmt_len - (whp_pkg::FMT_BASE_LEN - 1'b1)) & ~32'd1;

  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    gw_next        = gw;
    skip_next      = skip;
    fmt_len_next   = fmt_len;
    seen_fmt_next  = seen_fmt;
    seen_data_next = seen_data;
    chans_next     = chans;
    rate_next      = rate;
    brate_next     = brate;
    depth_next     = depth;
    dsize_next     = dsize;
    reported_next  = reported;
    do_end         = 1'b0;
    do_emit        = 1'b0;
    stat           = whp_pkg::STAT_OK;

    if (!reported) begin
      gw_next = gw_new;
      unique case (phase)
        whp_pkg::PH_RIFF, whp_pkg::PH_SIZE, whp_pkg::PH_WAVE,
        whp_pkg::PH_ID, whp_pkg::PH_DATA, whp_pkg::PH_CSIZE: begin
          pos_next = pos_inc;
          if (pos_inc == 5'd4) begin
            pos_next = '0;
            unique case (phase)
              whp_pkg::PH_RIFF: begin
                if (gw_new != whp_pkg::SIG_RIFF) begin
                  do_emit = 1'b1;
                  stat    = whp_pkg::STAT_NOT_RIFF;
                end else begin
                  phase_next = whp_pkg::PH_SIZE;
                end
              end
              whp_pkg::PH_SIZE: phase_next = whp_pkg::PH_WAVE;
              whp_pkg::PH_WAVE: begin
                if (gw_new != whp_pkg::SIG_WAVE) begin
                  do_emit = 1'b1;
                  stat    = whp_pkg::STAT_NOT_WAVE;
                end else begin
                  phase_next = whp_pkg::PH_ID;
                end
              end
              whp_pkg::PH_ID: begin
                if (gw_new == whp_pkg::SIG_FMT)       phase_next = whp_pkg::PH_FMT;
                else if (gw_new == whp_pkg::SIG_DATA) phase_next = whp_pkg::PH_DATA;
                else                                  phase_next = whp_pkg::PH_CSIZE;
              end
              whp_pkg::PH_DATA: begin
                dsize_next     = gw_new;
                seen_data_next = 1'b1;
                do_end         = 1'b1;
              end
              default: begin
                skip_next = pad_size;
                if (pad_size != '0) phase_next = whp_pkg::PH_SKIP;
                else                do_end     = 1'b1;
              end
            endcase
          end
        end
        whp_pkg::PH_FMT: begin
          pos_next = pos_inc;
          priority if (pos_inc == 5'd4)  fmt_len_next = gw_new;
          else if (pos_inc == 5'd8)      chans_next   = gw_new[31:16];
          else if (pos_inc == 5'd12)     rate_next    = gw_new;
          else if (pos_inc == 5'd16)     brate_next   = gw_new;
          else if (pos_inc >= whp_pkg::FMT_BODY_LEN) begin
            depth_next    = gw_new[31:16];
            seen_fmt_next = 1'b1;
            pos_next      = '0;
            if (fmt_len > whp_pkg::FMT_BASE_LEN) begin
              skip_next = ext_size;
              if (ext_size != '0) phase_next = whp_pkg::PH_SKIP;
              else                do_end     = 1'b1;
            end else begin
              skip_next = '0;
              do_end    = 1'b1;
            end
          end
        end
        whp_pkg::PH_SKIP: begin
          skip_next = (skip != '0) ? skip - 1'b1 : skip;
          if (skip_next == '0) do_end = 1'b1;
        end
        default: ;
      endcase

      if (do_end) begin
        phase_next = whp_pkg::PH_ID;
        pos_next   = '0;
        if (seen_fmt_next && seen_data_next) begin
          do_emit = 1'b1;
          stat    = (chans_next == '0 || brate_next == '0) ? whp_pkg::STAT_ZERO
                                                           : whp_pkg::STAT_OK;
        end
      end
      if (do_emit) reported_next = 1'b1;
    end

    if (end_of_file && !reported_next) begin
      do_emit = 1'b1;
      stat    = whp_pkg::STAT_TRUNC;
    end

    emit.valid     = do_emit;
    emit.status    = stat;
    emit.depth     = (stat == whp_pkg::STAT_OK) ? depth_next : '0;
    emit.rate      = (stat == whp_pkg::STAT_OK) ? rate_next  : '0;
    emit.channels  = (stat == whp_pkg::STAT_OK) ? chans_next : '0;
    emit.data_len  = dsize_next;
    emit.byte_rate = brate_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_file)) begin
      phase     <= whp_pkg::PH_RIFF;
      pos       <= '0;
      gw        <= '0;
      skip      <= '0;
      fmt_len   <= '0;
      seen_fmt  <= 1'b0;
      seen_data <= 1'b0;
      chans     <= '0;
      rate      <= '0;
      brate     <= '0;
      depth     <= '0;
      dsize     <= '0;
      reported  <= 1'b0;
    end else if (step) begin
      phase     <= phase_next;
      pos       <= pos_next;
      gw        <= gw_next;
      skip      <= skip_next;
      fmt_len   <= fmt_len_next;
      seen_fmt  <= seen_fmt_next;
      seen_data <= seen_data_next;
      chans     <= chans_next;
      rate      <= rate_next;
      brate     <= brate_next;
      depth     <= depth_next;
      dsize     <= dsize_next;
      reported  <= reported_next;
    end
  end

endmodule

/* sv/wav_header_parser_core.sv */
`timescale 1ns / 1ps
// RIFF/WAVE header parser, top level. Depends on whp_pkg, whp_parse, whp_div.
//
// Input channel (in_valid/in_ready, byte_value, end_of_file) carries one file
// byte per transaction; end_of_file marks the last byte of a file.
// Output channel (out_valid/out_ready) carries one result per file: status,
// bit_depth, sample_freq, channels and duration_seconds.
// Timing: while no result is pending, the header streams at one byte per clock.
// A byte that completes a good header starts the bit-serial divider (data size
// / byte rate); the result follows once the quotient is registered on done.
// Failure results appear on the cycle after the byte.
// While a result is being computed or waits on out_ready, in_ready is low;
// a stalled receiver therefore holds off the input stream.
// After the result, further bytes of the file are taken and ignored until the
// end_of_file byte, which returns the parser to its start state.
// Reset (rst, synchronous) clears the parser and drops any pending result.
module wav_header_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] bit_depth,
  output logic [31:0] sample_freq,
  output logic [15:0] channels,
  output logic [31:0] duration_seconds
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } seq_state_t;

  seq_state_t                 state;
  whp_pkg::emit_t             emit;
  logic                       accept;
  logic                       div_start;
  logic                       div_busy;
  logic                       div_done;
  logic [whp_pkg::WORD_W-1:0] div_quo;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign accept    = in_valid && in_ready;
  assign div_start = accept && emit.valid && (emit.status == whp_pkg::STAT_OK);

  whp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .byte_value  (byte_value),
    .end_of_file (end_of_file),
    .emit        (emit)
  );

  whp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (emit.data_len),
    .divisor  (emit.byte_rate),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (div_start)                 state <= ST_DIV;
          else if (accept && emit.valid) state <= ST_OUT;
        end
        ST_DIV:  if (div_done)  state <= ST_OUT;
        ST_OUT:  if (out_ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit.valid) begin
      status           <= emit.status;
      bit_depth        <= emit.depth;
      sample_freq      <= emit.rate;
      channels         <= emit.channels;
      duration_seconds <= '0;
    end else if (state == ST_DIV && div_done) begin
      duration_seconds <= div_quo;
    end
  end

  // divider only runs while the sequencer waits on it
  a_div_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == ST_DIV)
    else $error("divider busy outside divide state");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_fail_zeroed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != whp_pkg::STAT_OK) |->
      (duration_seconds == '0 && channels == '0 && sample_freq == '0 && bit_depth == '0))
    else $error("failure result carries non-zero fields");

  a_div_done_to_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_done) |=> out_valid)
    else $error("quotient not presented after divide");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for wav_header_parser_core: streams RIFF/WAVE files byte by byte
// and checks every result against a cycle-free header predictor. Depends on whp_pkg and wav_header_parser_core.
module testbench;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TARGET_BYTES   = 1800;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    whp_pkg::status_t status;
    logic [15:0]      depth;
    logic [31:0]      rate;
    logic [15:0]      chans;
    logic [31:0]      secs;
  } wav_result_t;

  typedef struct packed {
    logic [7:0]       b;
    logic             eof;
    logic             typed;
    whp_pkg::status_t st;
  } dir_row_t;

  typedef enum int {
    SC_PLAIN, SC_DATA_FIRST, SC_EXTRA_CHUNKS, SC_ZERO_CH, SC_ZERO_RATE,
    SC_REPEAT, SC_HUGE_SKIP, SC_TRUNC, SC_NOISE, SC_EXTREME, SC_COUNT
  } scen_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_value = 8'd0;
  logic        end_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] bit_depth;
  logic [31:0] sample_freq;
  logic [15:0] channels;
  logic [31:0] duration_seconds;

  wav_header_parser_core u_dut (
    .clk, .rst, .in_valid, .in_ready, .byte_value, .end_of_file,
    .out_valid, .out_ready, .status, .bit_depth, .sample_freq, .channels,
    .duration_seconds
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Short broken files whose outcome is obvious; typed rows carry the expected status
  dir_row_t dir_tab [0:24] = '{
    '{"R", 1'b0, 1'b0, whp_pkg::STAT_OK}, '{"I", 1'b0, 1'b0, whp_pkg::STAT_OK},
    '{"F", 1'b0, 1'b0, whp_pkg::STAT_OK},
    '{8'hFF, 1'b0, 1'b1, whp_pkg::STAT_NOT_RIFF},
    '{8'h00, 1'b0, 1'b0, whp_pkg::STAT_OK}, '{8'hFF, 1'b1, 1'b0, whp_pkg::STAT_OK},
    '{"R", 1'b1, 1'b1, whp_pkg::STAT_TRUNC},
    '{"R", 1'b0, 1'b0, whp_pkg::STAT_OK}, '{"I", 1'b0, 1'b0, whp_pkg::STAT_OK},
    '{"F", 1'b0, 1'b0, whp_pkg::STAT_OK}, '{"F", 1'b0, 1'b0, whp_pkg::STAT_OK},
    '{8'hFF, 1'b0, 1'b0, whp_pkg::STAT_OK}, '{8'hFF, 1'b0, 1'b0, whp_pkg::STAT_OK},
    '{8'hFF, 1'b0, 1'b0, whp_pkg::STAT_OK}, '{8'hFF, 1'b0, 1'b0, whp_pkg::STAT_OK},
    '{"W", 1'b0, 1'b0, whp_pkg::STAT_OK}, '{"A", 1'b0, 1'b0, whp_pkg::STAT_OK},
    '{"V", 1'b0, 1'b0, whp_pkg::STAT_OK},
    '{8'h00, 1'b0, 1'b1, whp_pkg::STAT_NOT_WAVE},
    '{8'h80, 1'b1, 1'b0, whp_pkg::STAT_OK},
    '{"R", 1'b0, 1'b0, whp_pkg::STAT_OK}, '{"I", 1'b0, 1'b0, whp_pkg::STAT_OK},
    '{"F", 1'b0, 1'b0, whp_pkg::STAT_OK}, '{"F", 1'b0, 1'b0, whp_pkg::STAT_OK},
    '{8'h00, 1'b1, 1'b1, whp_pkg::STAT_TRUNC}
  };

  // Header predictor state
  whp_pkg::phase_t ph;
  logic [4:0]  pos;
  logic [31:0] gw, skip_rem, fmt_len;
  logic        seen_fmt, seen_dat, done_flag;
  logic [15:0] h_ch, h_depth;
  logic [31:0] h_rate, h_brate, h_dsize;

  wav_result_t exp_q [$];
  logic [7:0]  file_q [$];
  int errors, files, all_bytes;
  int st_count [0:4];
  int snd_idle_pct, rcv_idle_pct;
  int quiet;

  function automatic void hdr_clear();
    ph = whp_pkg::PH_RIFF;
    pos = '0;
    gw = '0;
    skip_rem = '0;
    fmt_len = '0;
    seen_fmt = 1'b0;
    seen_dat = 1'b0;
    h_ch = '0;
    h_rate = '0;
    h_brate = '0;
    h_depth = '0;
    h_dsize = '0;
    done_flag = 1'b0;
  endfunction

  function automatic wav_result_t make_result(whp_pkg::status_t st);
    wav_result_t r;
    r = '{st, 16'd0, 32'd0, 16'd0, 32'd0};
    if (st == whp_pkg::STAT_OK) begin
      r.depth = h_depth;
      r.rate = h_rate;
      r.chans = h_ch;
      r.secs = (h_brate != 0) ? h_dsize / h_brate : 32'd0;
    end
    done_flag = 1'b1;
    return r;
  endfunction

  function automatic bit close_chunk(output wav_result_t r);
    ph = whp_pkg::PH_ID;
    pos = '0;
    if (seen_fmt && seen_dat) begin
      r = make_result((h_ch == 0 || h_brate == 0) ? whp_pkg::STAT_ZERO : whp_pkg::STAT_OK);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit hdr_predict(input logic [7:0] b, input logic eof,
                                     output wav_result_t r);
    bit got;
    got = 1'b0;
    r = '{whp_pkg::STAT_OK, 16'd0, 32'd0, 16'd0, 32'd0};
    if (!done_flag) begin
      gw = {b, gw[31:8]};
      case (ph)
        whp_pkg::PH_FMT: begin
          pos = pos + 5'd1;
          if (pos == 5'd4) fmt_len = gw;
          else if (pos == 5'd8) h_ch = gw[31:16];
          else if (pos == 5'd12) h_rate = gw;
          else if (pos == 5'd16) h_brate = gw;
          else if (pos >= whp_pkg::FMT_BODY_LEN) begin
            h_depth = gw[31:16];
            seen_fmt = 1'b1;
            pos = '0;
            // extension beyond the 16-byte base, padded to even
            skip_rem = (fmt_len > whp_pkg::FMT_BASE_LEN) ?
                       ((fmt_len - (whp_pkg::FMT_BASE_LEN - 32'd1)) & ~32'd1) : 32'd0;
            if (skip_rem != 0) ph = whp_pkg::PH_SKIP;
            else got = close_chunk(r);
          end
        end
        whp_pkg::PH_SKIP: begin
          if (skip_rem > 0) skip_rem = skip_rem - 32'd1;
          if (skip_rem == 0) got = close_chunk(r);
        end
        default: begin
          pos = pos + 5'd1;
          if (pos == 5'd4) begin
            pos = '0;
            case (ph)
              whp_pkg::PH_RIFF: begin
                if (gw != whp_pkg::SIG_RIFF) begin
                  r = make_result(whp_pkg::STAT_NOT_RIFF);
                  got = 1'b1;
                end else ph = whp_pkg::PH_SIZE;
              end
              whp_pkg::PH_SIZE: ph = whp_pkg::PH_WAVE;
              whp_pkg::PH_WAVE: begin
                if (gw != whp_pkg::SIG_WAVE) begin
                  r = make_result(whp_pkg::STAT_NOT_WAVE);
                  got = 1'b1;
                end else ph = whp_pkg::PH_ID;
              end
              whp_pkg::PH_ID: begin
                if (gw == whp_pkg::SIG_FMT) ph = whp_pkg::PH_FMT;
                else if (gw == whp_pkg::SIG_DATA) ph = whp_pkg::PH_DATA;
                else ph = whp_pkg::PH_CSIZE;
              end
              whp_pkg::PH_DATA: begin
                h_dsize = gw;
                seen_dat = 1'b1;
                got = close_chunk(r);
              end
              default: begin
                // size + 1 wraps, so an all-ones size skips nothing
                skip_rem = (gw + 32'd1) & ~32'd1;
                if (skip_rem != 0) ph = whp_pkg::PH_SKIP;
                else got = close_chunk(r);
              end
            endcase
          end
        end
      endcase
    end
    if (eof) begin
      if (!done_flag) begin
        r = make_result(whp_pkg::STAT_TRUNC);
        got = 1'b1;
      end
      hdr_clear();
    end
    return got;
  endfunction

  // File builders
  function automatic void put_byte(logic [7:0] b);
    file_q.insert(file_q.size(), b);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_half();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void put_word(logic [31:0] w);
    put_byte(w[7:0]);
    put_byte(w[15:8]);
    put_byte(w[23:16]);
    put_byte(w[31:24]);
  endfunction

  function automatic void put_half(logic [15:0] h);
    put_byte(h[7:0]);
    put_byte(h[15:8]);
  endfunction

  function automatic void put_other(bit huge);
    logic [31:0] id, sz, pad;
    id = $urandom;
    if (id == whp_pkg::SIG_FMT || id == whp_pkg::SIG_DATA) id = 32'h5453_494C;
    sz = huge ? 32'hFFFF_FFFF : 32'($urandom_range(0, 9));
    pad = (sz + 32'd1) & ~32'd1;
    put_word(id);
    put_word(sz);
    repeat (pad) put_byte(8'($urandom));
  endfunction

  function automatic void put_fmt(scen_t scen);
    logic [31:0] len, ext_len, brate;
    bit big;
    big = (scen == SC_EXTREME);
    if (scen == SC_EXTRA_CHUNKS || $urandom_range(0, 3) == 0)
      len = 32'($urandom_range(17, 24));
    else if ($urandom_range(0, 3) == 0)
      len = 32'($urandom_range(0, 15));
    else
      len = 32'd16;
    if (scen == SC_ZERO_RATE) brate = 32'd0;
    else if (big) brate = $urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF;
    else if ($urandom_range(0, 1)) brate = 32'($urandom_range(1, 200000));
    else brate = pick_word();
    put_word(whp_pkg::SIG_FMT);
    put_word(len);
    put_half(pick_half());
    put_half(scen == SC_ZERO_CH ? 16'd0 : big ? 16'hFFFF : pick_half());
    put_word(big ? 32'hFFFF_FFFF : pick_word());
    put_word(brate);
    put_half(pick_half());
    put_half(big ? 16'hFFFF : pick_half());
    ext_len = (len > 32'd16) ? ((len - 32'd15) & ~32'd1) : 32'd0;
    repeat (ext_len) put_byte(8'($urandom));
  endfunction

  function automatic void put_data(scen_t scen);
    put_word(whp_pkg::SIG_DATA);
    put_word(scen == SC_EXTREME ? 32'hFFFF_FFFF : pick_word());
  endfunction

  function automatic void build_file(scen_t scen);
    int n, keep, reps;
    bit dfirst;
    file_q.delete();
    if (scen == SC_NOISE) begin
      // broken stream: sometimes a valid preamble, then garbage
      if ($urandom_range(0, 1)) begin
        put_word(whp_pkg::SIG_RIFF);
        put_word(pick_word());
        if ($urandom_range(0, 1)) put_word(whp_pkg::SIG_WAVE);
      end
      n = $urandom_range(1, 40);
      repeat (n) put_byte(8'($urandom));
      return;
    end
    put_word(whp_pkg::SIG_RIFF);
    put_word(pick_word());
    put_word(whp_pkg::SIG_WAVE);
    if (scen == SC_EXTRA_CHUNKS || scen == SC_HUGE_SKIP || $urandom_range(0, 3) == 0)
      put_other(scen == SC_HUGE_SKIP || $urandom_range(0, 15) == 0);
    dfirst = (scen == SC_DATA_FIRST) || (scen != SC_PLAIN && $urandom_range(0, 1) == 1);
    reps = (scen == SC_REPEAT) ? 2 : 1;
    repeat (reps) begin
      if (dfirst) put_data(scen);
      else put_fmt(scen);
    end
    if (scen == SC_EXTRA_CHUNKS || $urandom_range(0, 3) == 0) put_other(1'b0);
    if (dfirst) put_fmt(scen);
    else put_data(scen);
    n = $urandom_range(0, 4);
    repeat (n) put_byte(8'($urandom));
    if (scen == SC_TRUNC || $urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, file_q.size() - 1);
      while (file_q.size() > keep) void'(file_q.pop_back());
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eof, input logic typed,
                           input whp_pkg::status_t st);
    wav_result_t r;
    bit got;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_value <= b;
    end_of_file <= eof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    all_bytes++;
    got = hdr_predict(b, eof, r);
    if (typed) begin
      r = '{st, 16'd0, 32'd0, 16'd0, 32'd0};
      got = 1'b1;
    end
    if (got) exp_q.insert(exp_q.size(), r);
  endtask

  // Sender holds off until every outstanding result has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_q.size() != 0) @(posedge clk);
  endtask

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Result side: check each transaction, then randomise ready for the next cycle
  always @(posedge clk) begin
    wav_result_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (exp_q.size() == 0) begin
          $error("unexpected result, status %0d", status);
          errors++;
        end else begin
          e = exp_q.pop_front();
          cmp_field("status", 32'(e.status), 32'(status));
          cmp_field("bit_depth", 32'(e.depth), 32'(bit_depth));
          cmp_field("sample_freq", e.rate, sample_freq);
          cmp_field("channels", 32'(e.chans), 32'(channels));
          cmp_field("duration_seconds", e.secs, duration_seconds);
          if (int'(e.status) <= 4) st_count[int'(e.status)]++;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int mode, cur_mode;
    scen_t scen;
    hdr_clear();
    snd_idle_pct = 35;
    rcv_idle_pct = 59;
    cur_mode = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 25; i++)
      send_byte(dir_tab[i].b, dir_tab[i].eof, dir_tab[i].typed, dir_tab[i].st);
    wait_drained();

    while (all_bytes < TARGET_BYTES) begin
      mode = (all_bytes < TARGET_BYTES / 3) ? 0 :
             (all_bytes < 2 * TARGET_BYTES / 3) ? 1 : 2;
      if (mode != cur_mode) begin
        wait_drained();
        cur_mode = mode;
        snd_idle_pct = (mode == 1) ? 59 : 0;
        rcv_idle_pct = (mode == 1) ? 35 : 0;
      end else if ($urandom_range(0, 19) == 0) begin
        wait_drained();
      end
      // first pass walks every scenario once, then pick at random
      scen = (files < SC_COUNT) ? scen_t'(files) : scen_t'($urandom_range(0, SC_COUNT - 1));
      build_file(scen);
      for (int i = 0; i < file_q.size(); i++)
        send_byte(file_q[i], i == file_q.size() - 1, 1'b0, whp_pkg::STAT_OK);
      files++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Streamed %0d files, %0d bytes in all, every scenario, under three pacing modes.",
             files, all_bytes);
    $display("Results: %0d ok, %0d bad RIFF, %0d bad WAVE, %0d truncated, %0d zero field.",
             st_count[0], st_count[1], st_count[2], st_count[3], st_count[4]);
    if (errors == 0 && exp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
